/* design/lta_pkg.sv */
`default_nettype none

package lta_pkg;

  localparam int KeyW   = 64;
  localparam int TimeW  = 48;
  localparam int CountW = 5;
  localparam int OpW    = 3;
  localparam int StatW  = 2;
  localparam int CfgW   = 64;
  localparam int AddrW  = 3;

  localparam logic [OpW-1:0] OP_PUT            = 3'd0;
  localparam logic [OpW-1:0] OP_LOOKUP         = 3'd1;
  localparam logic [OpW-1:0] OP_REMOVE         = 3'd2;
  localparam logic [OpW-1:0] OP_EVICT_UNPROVEN = 3'd3;
  localparam logic [OpW-1:0] OP_EVICT_STALE    = 3'd4;

  localparam logic [StatW-1:0] STATUS_OK        = 2'd0;
  localparam logic [StatW-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [StatW-1:0] STATUS_FULL      = 2'd2;

  localparam logic [CountW-1:0] COUNT_MAX = 5'd31;

  localparam logic [AddrW-1:0] REG_STALE_ADDR = 3'd0;

  // The probe walks the row of cells and collects the outcome of one operation.
  typedef struct packed {
    logic              valid;
    logic [OpW-1:0]    op;
    logic [KeyW-1:0]   key_hi;
    logic [KeyW-1:0]   key_lo;
    logic [TimeW-1:0]  now_time;
    logic              stale_en;
    logic              hit;
    logic              free_found;
    logic              hit_validated;
    logic [TimeW-1:0]  hit_deadline;
    logic [TimeW-1:0]  hit_activity;
    logic [CountW-1:0] count;
  } lta_probe_t;

  typedef struct packed {
    logic             en;
    logic [KeyW-1:0]  key_hi;
    logic [KeyW-1:0]  key_lo;
    logic             validated;
    logic [TimeW-1:0] deadline;
    logic [TimeW-1:0] activity;
  } lta_wr_t;

endpackage

`default_nettype wire

/* design/lta_cell.sv */
`default_nettype none

module lta_cell import lta_pkg::*; #(
  parameter int IdxW    = 4,
  parameter int CellIdx = 0
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire lta_probe_t      probe_i,
  input  wire logic [IdxW-1:0] hit_idx_i,
  input  wire logic [IdxW-1:0] free_idx_i,
  input  wire lta_wr_t         wr_i,
  input  wire logic [IdxW-1:0] wr_idx_i,
  output lta_probe_t           probe_o,
  output logic      [IdxW-1:0] hit_idx_o,
  output logic      [IdxW-1:0] free_idx_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CellIdx);

  logic             used_q, used_d;
  logic [KeyW-1:0]  key_hi_q, key_lo_q;
  logic             val_q;
  logic [TimeW-1:0] dl_q, act_q;

  lta_probe_t      probe_q, probe_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;

  logic key_match;
  logic evict;
  logic wr_here;

  assign wr_here   = wr_i.en && (wr_idx_i == MyIdx);
  assign key_match = used_q && (key_hi_q == probe_i.key_hi) && (key_lo_q == probe_i.key_lo);

  always_comb begin
    probe_d    = probe_i;
    hit_idx_d  = hit_idx_i;
    free_idx_d = free_idx_i;
    used_d     = used_q;
    evict      = 1'b0;
    if (probe_i.valid) begin
      case (probe_i.op)
        OP_PUT, OP_LOOKUP, OP_REMOVE: begin
          if (key_match) begin
            probe_d.hit = 1'b1;
            hit_idx_d   = MyIdx;
            if (probe_i.op == OP_LOOKUP) begin
              probe_d.hit_validated = val_q;
              probe_d.hit_deadline  = dl_q;
              probe_d.hit_activity  = act_q;
            end
            if (probe_i.op == OP_REMOVE) begin
              used_d = 1'b0;
            end
          end
          if (!used_q && !probe_i.free_found) begin
            probe_d.free_found = 1'b1;
            free_idx_d         = MyIdx;
          end
        end
        OP_EVICT_UNPROVEN: begin
          evict = used_q && !val_q && (dl_q != '0) && (dl_q <= probe_i.now_time);
        end
        OP_EVICT_STALE: begin
          evict = probe_i.stale_en && used_q && val_q && (act_q <= probe_i.now_time);
        end
        default: begin
        end
      endcase
    end
    if (evict) begin
      used_d        = 1'b0;
      probe_d.count = (probe_i.count == COUNT_MAX) ? COUNT_MAX
                                                   : probe_i.count + CountW'(1);
    end
    if (wr_here) begin
      used_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= 1'b0;
      probe_q <= '0;
    end else begin
      used_q  <= used_d;
      probe_q <= probe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    if (wr_here) begin
      key_hi_q <= wr_i.key_hi;
      key_lo_q <= wr_i.key_lo;
      val_q    <= wr_i.validated;
      dl_q     <= wr_i.deadline;
      act_q    <= wr_i.activity;
    end
  end

  assign probe_o    = probe_q;
  assign hit_idx_o  = hit_idx_q;
  assign free_idx_o = free_idx_q;

endmodule

`default_nettype wire

/* design/link_table_with_aging.sv */
// Link table with timeout aging: TABLE_ENTRIES links keyed by a 128-bit identifier.
// The input channel (in_valid_i / in_stall_o) carries one operation per transaction:
// put, lookup, remove, evict unproven or evict stale. The output channel
// (out_valid_o / out_stall_i) returns exactly one result transaction per operation.
// Each operation sends a probe down a row of cells, one cell per cycle; its outcome
// is captured in a done register and then moved into the output register. The next
// operation is accepted once the result has moved into the output register, even
// while that result still waits, so the block takes no new operation while a probe
// is still in the cell row or waits in the done register.
// A stalled result holds its value; the next operation then waits in the done state
// until the output register frees.
// Reset empties the table, clears the stale threshold and drops any transaction in
// flight. The user must write the stale threshold over the APB-style port only while the
// block is idle; the block does not enforce this. It is the only register, at address 0.
`default_nettype none

module link_table_with_aging import lta_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [AddrW-1:0]   paddr,
  input  wire logic [CfgW-1:0]    pwdata,
  output logic      [CfgW-1:0]    prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [OpW-1:0]     opcode_i,
  input  wire logic [KeyW-1:0]    link_id_hi_i,
  input  wire logic [KeyW-1:0]    link_id_lo_i,
  input  wire logic               entry_validated_i,
  input  wire logic [TimeW-1:0]   proof_deadline_i,
  input  wire logic [TimeW-1:0]   last_activity_i,
  input  wire logic [TimeW-1:0]   now_time_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [StatW-1:0]   status_o,
  output logic                    found_validated_o,
  output logic      [TimeW-1:0]   found_deadline_o,
  output logic      [TimeW-1:0]   found_activity_o,
  output logic      [CountW-1:0]  removed_count_o
);

  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_q, state_d;

  logic [TimeW-1:0] thr_q;

  lta_probe_t      probe_head;
  lta_probe_t      probe    [TABLE_ENTRIES+1];
  logic [IdxW-1:0] hit_idx  [TABLE_ENTRIES+1];
  logic [IdxW-1:0] free_idx [TABLE_ENTRIES+1];

  lta_probe_t      done_q;
  logic [IdxW-1:0] done_hit_idx_q, done_free_idx_q;

  logic             put_val_q;
  logic [TimeW-1:0] put_dl_q, put_act_q;

  lta_wr_t         wr;
  logic [IdxW-1:0] wr_idx;

  logic             in_accept, out_accept, out_free, commit;
  logic             stale_en;
  logic [TimeW-1:0] cutoff;
  logic [StatW-1:0] status_d;

  logic             out_valid_q;
  logic [StatW-1:0] status_q;
  logic             fval_q;
  logic [TimeW-1:0] fdl_q, fact_q;
  logic [CountW-1:0] count_q;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr == REG_STALE_ADDR) ? CfgW'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == REG_STALE_ADDR)) begin
      thr_q <= pwdata[TimeW-1:0];
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign commit     = (state_q == S_DONE) && out_free;

  assign stale_en = (now_time_i >= thr_q);
  assign cutoff   = now_time_i - thr_q;

  always_comb begin
    probe_head          = '0;
    probe_head.valid    = in_accept;
    probe_head.op       = opcode_i;
    probe_head.key_hi   = link_id_hi_i;
    probe_head.key_lo   = link_id_lo_i;
    probe_head.now_time = (opcode_i == OP_EVICT_STALE) ? cutoff : now_time_i;
    probe_head.stale_en = stale_en;
  end

  assign probe[0]    = probe_head;
  assign hit_idx[0]  = '0;
  assign free_idx[0] = '0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    lta_cell #(
      .IdxW    (IdxW),
      .CellIdx (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .probe_i    (probe[g]),
      .hit_idx_i  (hit_idx[g]),
      .free_idx_i (free_idx[g]),
      .wr_i       (wr),
      .wr_idx_i   (wr_idx),
      .probe_o    (probe[g+1]),
      .hit_idx_o  (hit_idx[g+1]),
      .free_idx_o (free_idx[g+1])
    );
  end

  // A put writes the matching slot, or else the lowest free one, once the probe is back.
  always_comb begin
    wr.en        = commit && (done_q.op == OP_PUT) && (done_q.hit || done_q.free_found);
    wr.key_hi    = done_q.key_hi;
    wr.key_lo    = done_q.key_lo;
    wr.validated = put_val_q;
    wr.deadline  = put_dl_q;
    wr.activity  = put_act_q;
    wr_idx       = done_q.hit ? done_hit_idx_q : done_free_idx_q;
  end

  always_comb begin
    case (done_q.op)
      OP_PUT: begin
        status_d = (done_q.hit || done_q.free_found) ? STATUS_OK : STATUS_FULL;
      end
      OP_LOOKUP, OP_REMOVE: begin
        status_d = done_q.hit ? STATUS_OK : STATUS_NOT_FOUND;
      end
      default: begin
        status_d = STATUS_OK;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (probe[TABLE_ENTRIES].valid) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_accept) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      put_val_q <= entry_validated_i;
      put_dl_q  <= proof_deadline_i;
      put_act_q <= last_activity_i;
    end
    if ((state_q == S_RUN) && probe[TABLE_ENTRIES].valid) begin
      done_q          <= probe[TABLE_ENTRIES];
      done_hit_idx_q  <= hit_idx[TABLE_ENTRIES];
      done_free_idx_q <= free_idx[TABLE_ENTRIES];
    end
    if (commit) begin
      status_q <= status_d;
      fval_q   <= done_q.hit_validated;
      fdl_q    <= done_q.hit_deadline;
      fact_q   <= done_q.hit_activity;
      count_q  <= done_q.count;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign found_validated_o = fval_q;
  assign found_deadline_o  = fdl_q;
  assign found_activity_o  = fact_q;
  assign removed_count_o   = count_q;

  a_probe_end_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    probe[TABLE_ENTRIES].valid |-> (state_q == S_RUN))
    else $error("probe left the cell row outside of a running operation");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result appeared without a finished operation");

  a_count_only_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && (done_q.op != OP_EVICT_UNPROVEN) &&
     (done_q.op != OP_EVICT_STALE)) |-> (done_q.count == '0))
    else $error("removal count set by an operation that is not a sweep");

endmodule

`default_nettype wire

/* tb/link_table_with_aging_test.sv */
`timescale 1ns / 1ps

module link_table_with_aging_test;
  import lta_pkg::*;

  localparam int Entries = 16;
  localparam int KeyPool = 24;
  localparam logic [TimeW-1:0] TimeMax = '1;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [KeyW-1:0]  key_hi;
    logic [KeyW-1:0]  key_lo;
    logic             validated;
    logic [TimeW-1:0] deadline;
    logic [TimeW-1:0] activity;
    logic [TimeW-1:0] now;
  } link_op_t;

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic              validated;
    logic [TimeW-1:0]  deadline;
    logic [TimeW-1:0]  activity;
    logic [CountW-1:0] removed;
  } link_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [CfgW-1:0]   pwdata = '0;
  logic [CfgW-1:0]   prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [OpW-1:0]    opcode_i = '0;
  logic [KeyW-1:0]   link_id_hi_i = '0;
  logic [KeyW-1:0]   link_id_lo_i = '0;
  logic              entry_validated_i = 1'b0;
  logic [TimeW-1:0]  proof_deadline_i = '0;
  logic [TimeW-1:0]  last_activity_i = '0;
  logic [TimeW-1:0]  now_time_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [StatW-1:0]  status_o;
  logic              found_validated_o;
  logic [TimeW-1:0]  found_deadline_o;
  logic [TimeW-1:0]  found_activity_o;
  logic [CountW-1:0] removed_count_o;

  link_table_with_aging #(.TABLE_ENTRIES(Entries)) dut (.*);

  // Shadow copy of the link table and its stale threshold.
  bit               tbl_used [Entries];
  logic [KeyW-1:0]  tbl_key_hi [Entries];
  logic [KeyW-1:0]  tbl_key_lo [Entries];
  bit               tbl_validated [Entries];
  logic [TimeW-1:0] tbl_deadline [Entries];
  logic [TimeW-1:0] tbl_activity [Entries];
  logic [TimeW-1:0] stale_threshold = '0;

  link_result_t     expected_results[$];

  logic [KeyW-1:0]  pool_hi [KeyPool];
  logic [KeyW-1:0]  pool_lo [KeyPool];
  logic [TimeW-1:0] time_base = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_hits = 0;
  int n_full = 0;
  int n_evicted = 0;
  int n_settings = 0;

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial forever begin
    @(negedge clk_i);
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic note_failure(input string msg);
    n_errors++;
    if (n_errors <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  function automatic int find_link(input logic [KeyW-1:0] hi, input logic [KeyW-1:0] lo);
    for (int i = 0; i < Entries; i++) begin
      if (tbl_used[i] && tbl_key_hi[i] == hi && tbl_key_lo[i] == lo) return i;
    end
    return -1;
  endfunction

  function automatic link_result_t table_step(input link_op_t t);
    link_result_t r;
    int slot;
    logic [TimeW-1:0] cutoff;
    r = '0;
    r.status = STATUS_OK;
    case (t.op)
      OP_PUT: begin
        slot = find_link(t.key_hi, t.key_lo);
        for (int i = Entries - 1; i >= 0; i--) begin
          if (find_link(t.key_hi, t.key_lo) < 0 && !tbl_used[i]) slot = i;
        end
        if (slot < 0) begin
          r.status = STATUS_FULL;
        end else begin
          tbl_used[slot] = 1'b1;
          tbl_key_hi[slot] = t.key_hi;
          tbl_key_lo[slot] = t.key_lo;
          tbl_validated[slot] = t.validated;
          tbl_deadline[slot] = t.deadline;
          tbl_activity[slot] = t.activity;
        end
      end
      OP_LOOKUP: begin
        slot = find_link(t.key_hi, t.key_lo);
        if (slot < 0) begin
          r.status = STATUS_NOT_FOUND;
        end else begin
          r.validated = tbl_validated[slot];
          r.deadline = tbl_deadline[slot];
          r.activity = tbl_activity[slot];
        end
      end
      OP_REMOVE: begin
        slot = find_link(t.key_hi, t.key_lo);
        if (slot < 0) r.status = STATUS_NOT_FOUND;
        else tbl_used[slot] = 1'b0;
      end
      OP_EVICT_UNPROVEN: begin
        for (int i = 0; i < Entries; i++) begin
          if (tbl_used[i] && !tbl_validated[i] && tbl_deadline[i] != '0 &&
              tbl_deadline[i] <= t.now) begin
            tbl_used[i] = 1'b0;
            if (r.removed != COUNT_MAX) r.removed++;
          end
        end
      end
      OP_EVICT_STALE: begin
        if (t.now >= stale_threshold) begin
          cutoff = t.now - stale_threshold;
          for (int i = 0; i < Entries; i++) begin
            if (tbl_used[i] && tbl_validated[i] && tbl_activity[i] <= cutoff) begin
              tbl_used[i] = 1'b0;
              if (r.removed != COUNT_MAX) r.removed++;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic link_op_t make_op(input logic [OpW-1:0] op, input logic [KeyW-1:0] hi,
                                       input logic [KeyW-1:0] lo, input logic val,
                                       input logic [TimeW-1:0] dl, input logic [TimeW-1:0] act,
                                       input logic [TimeW-1:0] now);
    link_op_t t;
    t.op = op;
    t.key_hi = hi;
    t.key_lo = lo;
    t.validated = val;
    t.deadline = dl;
    t.activity = act;
    t.now = now;
    return t;
  endfunction

  // Called and returns at a falling edge.
  task automatic send_link_op(input link_op_t t);
    link_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= t.op;
    link_id_hi_i <= t.key_hi;
    link_id_lo_i <= t.key_lo;
    entry_validated_i <= t.validated;
    proof_deadline_i <= t.deadline;
    last_activity_i <= t.activity;
    now_time_i <= t.now;
    do @(posedge clk_i); while (in_stall_o);
    r = table_step(t);
    expected_results.push_back(r);
    n_sent++;
    if (t.op == OP_LOOKUP && r.status == STATUS_OK) n_hits++;
    if (r.status == STATUS_FULL) n_full++;
    n_evicted += r.removed;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_stale_threshold(input logic [TimeW-1:0] value);
    logic [CfgW-1:0] rd;
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_STALE_ADDR;
    pwdata <= CfgW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    stale_threshold = value;
    n_settings++;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[TimeW-1:0] !== value) begin
      note_failure($sformatf("stale threshold readback: expected %h, got %h", value, rd));
    end
  endtask

  function automatic logic [TimeW-1:0] random_time();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    case ($urandom_range(9))
      0: return '0;
      1: return TimeMax;
      2: return wide[TimeW-1:0];
      default: return time_base + TimeW'($urandom_range(3000));
    endcase
  endfunction

  function automatic link_op_t random_link_op();
    link_op_t t;
    int pick;
    int k;
    pick = $urandom_range(99);
    if (pick < 40) t.op = OP_PUT;
    else if (pick < 65) t.op = OP_LOOKUP;
    else if (pick < 77) t.op = OP_REMOVE;
    else if (pick < 86) t.op = OP_EVICT_UNPROVEN;
    else if (pick < 95) t.op = OP_EVICT_STALE;
    else t.op = OpW'($urandom_range(OP_EVICT_STALE + 1, {OpW{1'b1}}));
    k = $urandom_range(KeyPool - 1);
    t.key_hi = pool_hi[k];
    t.key_lo = pool_lo[k];
    if ($urandom_range(19) == 0) begin
      t.key_hi = {$urandom, $urandom};
      t.key_lo = {$urandom, $urandom};
    end
    t.validated = 1'($urandom_range(1));
    t.deadline = ($urandom_range(3) == 0) ? '0 : random_time();
    t.activity = random_time();
    t.now = random_time();
    return t;
  endfunction

  always @(posedge clk_i) begin
    link_result_t got;
    link_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {status_o, found_validated_o, found_deadline_o, found_activity_o, removed_count_o};
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected result transaction %p", got));
      end else begin
        want = expected_results.pop_front();
        n_checked++;
        if (got.status !== want.status || got.validated !== want.validated ||
            got.deadline !== want.deadline || got.activity !== want.activity ||
            got.removed !== want.removed) begin
          note_failure($sformatf("result mismatch: expected %p, got %p", want, got));
        end
      end
    end
  end

  task automatic test_single_link();
    logic [KeyW-1:0] ones;
    ones = '1;
    send_link_op(make_op(OP_LOOKUP, '0, '0, 1'b0, '0, '0, '0));
    send_link_op(make_op(OP_REMOVE, '0, '0, 1'b0, '0, '0, '0));
    send_link_op(make_op(OP_PUT, ones, ones, 1'b1, TimeMax, TimeMax, '0));
    send_link_op(make_op(OP_LOOKUP, ones, ones, 1'b0, '0, '0, '0));
    send_link_op(make_op(OP_PUT, ones, ones, 1'b0, 48'd5, '0, '0));
    send_link_op(make_op(OP_LOOKUP, ones, ones, 1'b0, '0, '0, '0));
    send_link_op(make_op(OP_EVICT_UNPROVEN, '0, '0, 1'b0, '0, '0, 48'd4));
    send_link_op(make_op(OP_EVICT_UNPROVEN, '0, '0, 1'b0, '0, '0, 48'd5));
  endtask

  task automatic test_table_full();
    for (int i = 0; i < Entries; i++) begin
      send_link_op(make_op(OP_PUT, {$urandom, $urandom}, KeyW'(i), i[0],
                           TimeW'(i * 10), TimeW'(i * 100), '0));
    end
    send_link_op(make_op(OP_PUT, '1, '0, 1'b1, '0, '0, '0));
    send_link_op(make_op(OP_EVICT_STALE, '0, '0, 1'b0, '0, '0, TimeW'(500)));
    send_link_op(make_op({OpW{1'b1}}, '1, '1, 1'b1, TimeMax, TimeMax, TimeMax));
  endtask

  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct,
                                     input logic [TimeW-1:0] threshold);
    logic [63:0] wide;
    link_op_t t;
    set_stale_threshold(threshold);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int k = 0; k < KeyPool; k++) begin
      pool_hi[k] = {$urandom, $urandom};
      pool_lo[k] = {$urandom, $urandom};
    end
    wide = {$urandom, $urandom};
    time_base = wide[TimeW-1:0];
    // Drop leftovers of the previous phase so the new key pool can fill the table.
    for (int i = 0; i < Entries; i++) begin
      if (tbl_used[i]) begin
        send_link_op(make_op(OP_REMOVE, tbl_key_hi[i], tbl_key_lo[i], 1'b0, '0, '0, '0));
      end
    end
    for (int n = 0; n < count; n++) begin
      t = random_link_op();
      send_link_op(t);
      if ($urandom_range(99) == 0) wait_idle();
    end
  endtask

  initial begin
    logic [63:0] wide;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    set_stale_threshold('0);
    test_single_link();
    test_table_full();
    test_random_traffic(375, 20, 65, 48'd1000);
    test_random_traffic(375, 65, 20, TimeMax);
    test_random_traffic(375, 0, 0, '0);
    wide = {$urandom, $urandom};
    test_random_traffic(375, 0, 0, wide[TimeW-1:0]);
    wait_idle();
    repeat (Entries + 10) @(posedge clk_i);
    $display("Sent %0d link operations and checked %0d results: %0d lookup hits, %0d full puts.",
             n_sent, n_checked, n_hits, n_full);
    $display("Sweeps evicted %0d links over %0d stale threshold settings; %0d mismatches.",
             n_evicted, n_settings, n_errors);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
